FILE: sv/spf_pkg.sv
// Shared constants, register indexes and controller/datapath types for the peak finder.
`default_nettype none

package spf_pkg;

    // Configuration port geometry.
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_WINDOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WEAK_FRACTION = 3'd5;

    // Register widths and reset values.
    localparam int NW_W    = 8;
    localparam int GAIN_W  = 8;
    localparam int FIRST_W = 10;
    localparam int END_W   = 11;
    localparam int BW_W    = 20;
    localparam int WEAK_W  = 17;

    localparam logic [NW_W-1:0]    RST_NOISE_WINDOW  = 8'd102;
    localparam logic [GAIN_W-1:0]  RST_NOISE_GAIN    = 8'd10;
    localparam logic [FIRST_W-1:0] RST_FIRST_BIN     = 10'd2;
    localparam logic [END_W-1:0]   RST_END_BIN       = 11'd512;
    localparam logic [BW_W-1:0]    RST_BIN_WIDTH     = 20'd64000;
    localparam logic [WEAK_W-1:0]  RST_WEAK_FRACTION = 17'd3277;

    // Result field widths and fixed-point formats.
    localparam int FREQ_W  = 24;
    localparam int LEVEL_W = 17;
    localparam int TOTAL_W = 4;
    localparam int FRAC_W  = 16;
    localparam int QUOT_W  = 18;

    // Source of the store read address.
    typedef enum logic [1:0] {
        RD_NONE,
        RD_CAND,
        RD_WIN,
        RD_SCAN
    } t_rd_sel;

    // Operand set for the shared divider.
    typedef enum logic {
        DIV_INTERP,
        DIV_LEVEL
    } t_div_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        t_rd_sel  rd;
        logic     med_init;
        logic     cand_cap;
        logic     win_acc;
        logic     cand_next;
        logic     floor_mul;
        logic     scan_init;
        logic     scan_shift;
        logic     div_go;
        t_div_sel div_sel;
        logic     freq_mul;
        logic     keep_new;
        logic     min_init;
        logic     min_step;
        logic     keep_repl;
        logic     max_init;
        logic     max_step;
        logic     norm_init;
        logic     norm_keep;
        logic     out_init;
        logic     sel_init;
        logic     sel_step;
        logic     emit;
        logic     emit_empty;
        logic     finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic win_last;
        logic med_found;
        logic scan_more;
        logic is_peak;
        logic div_done;
        logic table_full;
        logic k_end_full;
        logic k_end_cnt;
        logic k_end_n;
        logic none;
        logic out_last;
    } t_stat;

endpackage

`default_nettype wire

FILE: sv/spf_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module spf_div #(
    parameter int NW = 41,
    parameter int DW = 27,
    parameter int QW = 18
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [QW-1:0] o_quot
);

    localparam int SW = (NW > DW + QW - 1) ? NW : DW + QW - 1;
    localparam int LW = $clog2(QW + 1);

    logic [SW-1:0] r_rem;
    logic [SW-1:0] r_dsh;
    logic [QW-1:0] r_q;
    logic [LW-1:0] r_left;
    logic          r_run;
    logic          r_done;

    // Control: run flag, bit counter and done flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else if (i_go) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_left <= LW'(QW);
        end else if (r_run) begin
            r_left <= r_left - 1'b1;
            if (r_left == LW'(1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: trial subtraction of the shifted divisor.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= SW'(i_num);
            r_dsh <= SW'(i_den) << (QW - 1);
            r_q   <= '0;
        end else if (r_run) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_q   <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[QW-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

FILE: sv/spf_datapath.sv
// Datapath: registers, spectrum store, median counters, scan window, peak tables, divider.
`default_nettype none

module spf_datapath #(
    parameter int NUM_BINS         = 1024,
    parameter int MAX_KEPT         = 10,
    parameter int NOISE_WINDOW_MAX = 128,
    parameter int MAG_WIDTH        = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [spf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [spf_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [MAG_WIDTH-1:0]           i_magnitude,
    input  spf_pkg::t_cmd                  i_cmd,
    output spf_pkg::t_stat                 o_stat,
    output logic [spf_pkg::FREQ_W-1:0]     o_peak_freq,
    output logic [spf_pkg::LEVEL_W-1:0]    o_peak_level,
    output logic [spf_pkg::TOTAL_W-1:0]    o_peak_total,
    output logic                           o_peak_valid,
    output logic                           o_last_peak,
    output logic                           o_peak_strobe
);

    import spf_pkg::*;

    localparam int AW  = $clog2(NUM_BINS);
    localparam int CW  = $clog2(NUM_BINS + 1);
    localparam int WW  = $clog2(NOISE_WINDOW_MAX + 1);
    localparam int XW  = $clog2(NUM_BINS + NOISE_WINDOW_MAX + 1025);
    localparam int KW  = $clog2(MAX_KEPT + 1);
    localparam int KI  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int FLW = MAG_WIDTH + GAIN_W;
    localparam int DNW = MAG_WIDTH + FRAC_W + 1;
    localparam int DDW = MAG_WIDTH + 3;
    localparam int PW  = AW + FRAC_W + 1;
    localparam int PRW = PW + BW_W;
    localparam int FSW = (PRW + 1 > 49) ? PRW + 1 : 49;

    // Configuration registers.
    logic [NW_W-1:0]    r_nw;
    logic [GAIN_W-1:0]  r_gain;
    logic [FIRST_W-1:0] r_first;
    logic [END_W-1:0]   r_end;
    logic [BW_W-1:0]    r_bw;
    logic [WEAK_W-1:0]  r_weak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nw    <= RST_NOISE_WINDOW;
            r_gain  <= RST_NOISE_GAIN;
            r_first <= RST_FIRST_BIN;
            r_end   <= RST_END_BIN;
            r_bw    <= RST_BIN_WIDTH;
            r_weak  <= RST_WEAK_FRACTION;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NOISE_WINDOW:  r_nw    <= i_cfg_data[NW_W-1:0];
                CFG_NOISE_GAIN:    r_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_FIRST_BIN:     r_first <= i_cfg_data[FIRST_W-1:0];
                CFG_END_BIN:       r_end   <= i_cfg_data[END_W-1:0];
                CFG_BIN_WIDTH:     r_bw    <= i_cfg_data[BW_W-1:0];
                CFG_WEAK_FRACTION: r_weak  <= i_cfg_data[WEAK_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective window length and search end.
    logic [WW-1:0] win_n;
    logic [WW-1:0] half;
    logic [XW-1:0] end_eff;

    always_comb begin
        if (r_nw == '0) begin
            win_n = WW'(1);
        end else if (XW'(r_nw) > XW'(NOISE_WINDOW_MAX)) begin
            win_n = WW'(NOISE_WINDOW_MAX);
        end else begin
            win_n = WW'(r_nw);
        end
        half    = win_n >> 1;
        end_eff = (XW'(r_end) > XW'(NUM_BINS)) ? XW'(NUM_BINS) : XW'(r_end);
    end

    // Bin counter.
    logic [CW-1:0] r_cnt;
    logic          store_we;

    assign store_we = i_cmd.load && (r_cnt < CW'(NUM_BINS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.finish) begin
            r_cnt <= '0;
        end else if (store_we) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Spectrum store: one write port, one registered read port.
    logic [MAG_WIDTH-1:0] r_store [NUM_BINS];
    logic [MAG_WIDTH-1:0] r_rd_data;
    logic                 r_rd_ok;
    logic [XW-1:0]        rd_addr;
    logic [MAG_WIDTH-1:0] rd_val;

    logic [WW-1:0] r_ci;
    logic [WW-1:0] r_wj;
    logic [XW-1:0] r_p;

    always_comb begin
        case (i_cmd.rd)
            RD_CAND: rd_addr = XW'(r_first) + XW'(r_ci);
            RD_WIN:  rd_addr = XW'(r_first) + XW'(r_wj);
            RD_SCAN: rd_addr = r_p;
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_cnt[AW-1:0]] <= i_magnitude;
        end
        if (i_cmd.rd != RD_NONE) begin
            r_rd_data <= r_store[rd_addr[AW-1:0]];
        end
    end

    // Bins past the loaded count read as zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd != RD_NONE) begin
            r_rd_ok <= rd_addr < XW'(r_cnt);
        end
    end

    assign rd_val = r_rd_ok ? r_rd_data : '0;

    // Working registers.
    logic [MAG_WIDTH-1:0] r_cand;
    logic [WW-1:0]        r_lt;
    logic [WW-1:0]        r_le;
    logic [FLW-1:0]       r_floor;
    logic [MAG_WIDTH-1:0] r_a;
    logic [MAG_WIDTH-1:0] r_b;
    logic [MAG_WIDTH-1:0] r_g;
    logic [1:0]           r_fill;
    logic                 r_sgn;
    logic [PRW-1:0]       r_prod;
    logic [KW-1:0]        r_count;
    logic [KW-1:0]        r_k;
    logic [KW-1:0]        r_n;
    logic [KW-1:0]        r_e;
    logic [KI-1:0]        r_mn;
    logic [MAG_WIDTH-1:0] r_minv;
    logic [MAG_WIDTH-1:0] r_max;
    logic [KI-1:0]        r_best;
    logic [FREQ_W-1:0]    r_bestf;
    logic                 r_have;
    logic [MAX_KEPT-1:0]  r_em;
    logic [FREQ_W-1:0]    r_freq [MAX_KEPT];
    logic [MAG_WIDTH-1:0] r_mag  [MAX_KEPT];
    logic [LEVEL_W-1:0]   r_lv   [MAX_KEPT];

    // Shared divider and its operand selection.
    logic [MAG_WIDTH-1:0] diff;
    logic [DDW-1:0]       d2;
    logic [DNW-1:0]       div_num;
    logic [DDW-1:0]       div_den;
    logic                 div_done;
    logic [QUOT_W-1:0]    div_q;
    logic [MAG_WIDTH-1:0] mag_k;
    logic [FREQ_W-1:0]    freq_k;
    logic [LEVEL_W-1:0]   lvl;

    assign mag_k  = r_mag[r_k[KI-1:0]];
    assign freq_k = r_freq[r_k[KI-1:0]];
    assign lvl    = div_q[LEVEL_W-1:0];

    always_comb begin
        diff = (r_g >= r_a) ? r_g - r_a : r_a - r_g;
        d2   = DDW'({r_b, 2'b00}) - DDW'({r_a, 1'b0}) - DDW'({r_g, 1'b0});
        if (i_cmd.div_sel == DIV_INTERP) begin
            div_num = DNW'({diff, FRAC_W'(0)}) + DNW'(d2 >> 1);
            div_den = d2;
        end else begin
            div_num = DNW'({mag_k, FRAC_W'(0)}) + DNW'(r_max >> 1);
            div_den = DDW'(r_max);
        end
    end

    spf_div #(
        .NW(DNW),
        .DW(DDW),
        .QW(QUOT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // Interpolated position and rounded, saturated frequency.
    logic [AW-1:0]  ctr;
    logic [PW-1:0]  pos_base;
    logic [PW-1:0]  pos;
    logic [FSW-1:0] f_sum;
    logic [FREQ_W-1:0] f_new;

    always_comb begin
        ctr      = AW'(r_p - XW'(2));
        pos_base = PW'({ctr, FRAC_W'(0)});
        pos      = r_sgn ? pos_base + PW'(div_q) : pos_base - PW'(div_q);
        f_sum    = FSW'(r_prod) + FSW'(1 << 23);
        f_new    = (|f_sum[FSW-1:48]) ? '1 : f_sum[47:24];
    end

    // Sequenced work: median, scan, keep, normalize, ordered output.
    always_ff @(posedge i_clk) begin
        // Median by rank counting.
        if (i_cmd.med_init) begin
            r_ci <= '0;
        end else if (i_cmd.cand_next) begin
            r_ci <= r_ci + 1'b1;
        end
        if (i_cmd.cand_cap) begin
            r_cand <= rd_val;
            r_lt   <= '0;
            r_le   <= '0;
            r_wj   <= '0;
        end else if (i_cmd.win_acc) begin
            r_lt <= r_lt + WW'(rd_val < r_cand);
            r_le <= r_le + WW'(rd_val <= r_cand);
            r_wj <= r_wj + 1'b1;
        end
        if (i_cmd.floor_mul) begin
            r_floor <= FLW'(r_cand) * FLW'(r_gain);
        end

        // Three-bin sliding window.
        if (i_cmd.scan_init) begin
            r_p    <= XW'(r_first);
            r_fill <= '0;
        end else if (i_cmd.scan_shift) begin
            r_a <= r_b;
            r_b <= r_g;
            r_g <= rd_val;
            r_p <= r_p + 1'b1;
            if (r_fill != 2'd3) begin
                r_fill <= r_fill + 1'b1;
            end
        end

        // Interpolation and frequency product.
        if (i_cmd.div_go && i_cmd.div_sel == DIV_INTERP) begin
            r_sgn <= r_g >= r_a;
        end
        if (i_cmd.freq_mul) begin
            r_prod <= PRW'(pos) * PRW'(r_bw);
        end

        // Shared table index.
        if (i_cmd.min_init) begin
            r_k <= KW'(1);
        end else if (i_cmd.max_init || i_cmd.norm_init || i_cmd.sel_init) begin
            r_k <= '0;
        end else if (i_cmd.min_step || i_cmd.max_step || i_cmd.norm_keep ||
                     i_cmd.sel_step) begin
            r_k <= r_k + 1'b1;
        end

        // Peak table fill and replacement of the first smallest entry.
        if (i_cmd.scan_init) begin
            r_count <= '0;
        end else if (i_cmd.keep_new) begin
            r_freq[r_count[KI-1:0]] <= f_new;
            r_mag[r_count[KI-1:0]]  <= r_b;
            r_count                 <= r_count + 1'b1;
        end
        if (i_cmd.min_init) begin
            r_minv <= r_mag[0];
            r_mn   <= '0;
        end else if (i_cmd.min_step && mag_k < r_minv) begin
            r_minv <= mag_k;
            r_mn   <= r_k[KI-1:0];
        end
        if (i_cmd.keep_repl && r_b > r_minv) begin
            r_freq[r_mn] <= f_new;
            r_mag[r_mn]  <= r_b;
        end

        // Largest kept magnitude.
        if (i_cmd.max_init) begin
            r_max <= '0;
        end else if (i_cmd.max_step && mag_k > r_max) begin
            r_max <= mag_k;
        end

        // Normalize and drop weak peaks, compacting in place.
        if (i_cmd.norm_init) begin
            r_n <= '0;
        end else if (i_cmd.norm_keep && lvl >= r_weak) begin
            r_freq[r_n[KI-1:0]] <= freq_k;
            r_lv[r_n[KI-1:0]]   <= lvl;
            r_n                 <= r_n + 1'b1;
        end

        // Output order: smallest unsent frequency, first one on ties.
        if (i_cmd.out_init) begin
            r_em <= '0;
            r_e  <= '0;
        end else if (i_cmd.emit) begin
            r_em[r_best] <= 1'b1;
            r_e          <= r_e + 1'b1;
        end
        if (i_cmd.sel_init) begin
            r_have <= 1'b0;
        end else if (i_cmd.sel_step && !r_em[r_k[KI-1:0]] &&
                     (!r_have || freq_k < r_bestf)) begin
            r_have  <= 1'b1;
            r_best  <= r_k[KI-1:0];
            r_bestf <= freq_k;
        end
    end

    // Result register and its strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_peak_strobe <= 1'b0;
        end else begin
            o_peak_strobe <= i_cmd.emit || i_cmd.emit_empty;
        end
        if (i_cmd.emit) begin
            o_peak_freq  <= r_bestf;
            o_peak_level <= r_lv[r_best];
            o_peak_total <= TOTAL_W'(r_n);
            o_peak_valid <= 1'b1;
            o_last_peak  <= o_stat.out_last;
        end else if (i_cmd.emit_empty) begin
            o_peak_freq  <= '0;
            o_peak_level <= '0;
            o_peak_total <= '0;
            o_peak_valid <= 1'b0;
            o_last_peak  <= 1'b1;
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.win_last   = r_wj == win_n - 1'b1;
        o_stat.med_found  = (r_lt <= half) && (half < r_le);
        o_stat.scan_more  = r_p < end_eff;
        o_stat.is_peak    = (r_fill == 2'd3) && (FLW'(r_b) > r_floor) &&
                            (r_b > r_a) && (r_b > r_g);
        o_stat.div_done   = div_done;
        o_stat.table_full = r_count == KW'(MAX_KEPT);
        o_stat.k_end_full = r_k == KW'(MAX_KEPT);
        o_stat.k_end_cnt  = r_k == r_count;
        o_stat.k_end_n    = r_k == r_n;
        o_stat.none       = r_n == '0;
        o_stat.out_last   = (r_e + KW'(1)) == r_n;
    end

endmodule

`default_nettype wire

FILE: sv/spf_ctrl.sv
// Controller state machine that sequences load, median, scan, normalize and output.
`default_nettype none

module spf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_last_bin,
    input  spf_pkg::t_stat i_stat,
    output spf_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    import spf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CAND_RD,
        S_CAND_CAP,
        S_WIN_RD,
        S_WIN_ACC,
        S_MED_CHK,
        S_FLOOR,
        S_SCAN_INIT,
        S_SCAN_TEST,
        S_SCAN_RD,
        S_SCAN_SH,
        S_SCAN_EVAL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FREQ_MUL,
        S_KEEP,
        S_MIN_SCAN,
        S_REPL,
        S_MAX_INIT,
        S_MAX,
        S_NORM_INIT,
        S_NORM_TEST,
        S_NORM_WAIT,
        S_NORM_KEEP,
        S_OUT_INIT,
        S_EMPTY,
        S_SEL_INIT,
        S_SEL_STEP,
        S_EMIT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   accept;

    assign accept = i_start && !r_busy;

    // Next state and command decode.
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.rd      = RD_NONE;
        o_cmd.div_sel = DIV_INTERP;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = accept;
                if (accept && i_last_bin) begin
                    o_cmd.med_init = 1'b1;
                    n_state        = S_CAND_RD;
                end
            end
            S_CAND_RD: begin
                o_cmd.rd = RD_CAND;
                n_state  = S_CAND_CAP;
            end
            S_CAND_CAP: begin
                o_cmd.cand_cap = 1'b1;
                n_state        = S_WIN_RD;
            end
            S_WIN_RD: begin
                o_cmd.rd = RD_WIN;
                n_state  = S_WIN_ACC;
            end
            S_WIN_ACC: begin
                o_cmd.win_acc = 1'b1;
                n_state       = i_stat.win_last ? S_MED_CHK : S_WIN_RD;
            end
            S_MED_CHK: begin
                if (i_stat.med_found) begin
                    n_state = S_FLOOR;
                end else begin
                    o_cmd.cand_next = 1'b1;
                    n_state         = S_CAND_RD;
                end
            end
            S_FLOOR: begin
                o_cmd.floor_mul = 1'b1;
                n_state         = S_SCAN_INIT;
            end
            S_SCAN_INIT: begin
                o_cmd.scan_init = 1'b1;
                n_state         = S_SCAN_TEST;
            end
            S_SCAN_TEST: begin
                n_state = i_stat.scan_more ? S_SCAN_RD : S_MAX_INIT;
            end
            S_SCAN_RD: begin
                o_cmd.rd = RD_SCAN;
                n_state  = S_SCAN_SH;
            end
            S_SCAN_SH: begin
                o_cmd.scan_shift = 1'b1;
                n_state          = S_SCAN_EVAL;
            end
            S_SCAN_EVAL: begin
                n_state = i_stat.is_peak ? S_DIV_GO : S_SCAN_TEST;
            end
            S_DIV_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DIV_INTERP;
                n_state       = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_FREQ_MUL;
                end
            end
            S_FREQ_MUL: begin
                o_cmd.freq_mul = 1'b1;
                n_state        = S_KEEP;
            end
            S_KEEP: begin
                if (i_stat.table_full) begin
                    o_cmd.min_init = 1'b1;
                    n_state        = S_MIN_SCAN;
                end else begin
                    o_cmd.keep_new = 1'b1;
                    n_state        = S_SCAN_TEST;
                end
            end
            S_MIN_SCAN: begin
                if (i_stat.k_end_full) begin
                    n_state = S_REPL;
                end else begin
                    o_cmd.min_step = 1'b1;
                end
            end
            S_REPL: begin
                o_cmd.keep_repl = 1'b1;
                n_state         = S_SCAN_TEST;
            end
            S_MAX_INIT: begin
                o_cmd.max_init = 1'b1;
                n_state        = S_MAX;
            end
            S_MAX: begin
                if (i_stat.k_end_cnt) begin
                    n_state = S_NORM_INIT;
                end else begin
                    o_cmd.max_step = 1'b1;
                end
            end
            S_NORM_INIT: begin
                o_cmd.norm_init = 1'b1;
                n_state         = S_NORM_TEST;
            end
            S_NORM_TEST: begin
                if (i_stat.k_end_cnt) begin
                    n_state = S_OUT_INIT;
                end else begin
                    o_cmd.div_go  = 1'b1;
                    o_cmd.div_sel = DIV_LEVEL;
                    n_state       = S_NORM_WAIT;
                end
            end
            S_NORM_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_NORM_KEEP;
                end
            end
            S_NORM_KEEP: begin
                o_cmd.norm_keep = 1'b1;
                n_state         = S_NORM_TEST;
            end
            S_OUT_INIT: begin
                o_cmd.out_init = 1'b1;
                n_state        = i_stat.none ? S_EMPTY : S_SEL_INIT;
            end
            S_EMPTY: begin
                o_cmd.emit_empty = 1'b1;
                n_state          = S_DONE;
            end
            S_SEL_INIT: begin
                o_cmd.sel_init = 1'b1;
                n_state        = S_SEL_STEP;
            end
            S_SEL_STEP: begin
                if (i_stat.k_end_n) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.sel_step = 1'b1;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = i_stat.out_last ? S_DONE : S_SEL_INIT;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_state != S_IDLE;
        end
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

FILE: sv/spectrum_peak_finder.sv
// Top level of the spectral peak finder: controller, datapath and port checks.
`default_nettype none

// Bins are loaded one per cycle with start while busy is low; the beat that carries
// last_bin raises busy, and busy stays high until the report is done. The time with
// busy high is set by the single read port of the spectrum store and the shared
// divider: the median is found by rank counting, candidate by candidate, over a
// window of W bins, the scan reads each searched bin and divides once per local
// maximum, with a pass over the table when it is full, normalizing divides once per
// kept peak, and the output makes a pass over the table for each reported peak. Each
// result is shown for one cycle with o_peak_strobe and cannot be held off; the last
// strobe comes in the final cycle with busy high. An empty report is one beat with
// o_peak_valid low. Configuration writes take effect at once and belong between
// spectra. No clearing pass follows reset.
module spectrum_peak_finder #(
    parameter int NUM_BINS         = 1024,
    parameter int MAX_KEPT         = 10,
    parameter int NOISE_WINDOW_MAX = 128,
    parameter int MAG_WIDTH        = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [spf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [spf_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [MAG_WIDTH-1:0]          i_magnitude,
    input  logic                          i_last_bin,
    output logic [spf_pkg::FREQ_W-1:0]    o_peak_freq,
    output logic [spf_pkg::LEVEL_W-1:0]   o_peak_level,
    output logic [spf_pkg::TOTAL_W-1:0]   o_peak_total,
    output logic                          o_peak_valid,
    output logic                          o_last_peak,
    output logic                          o_peak_strobe
);

    import spf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    spf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_last_bin (i_last_bin),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    // Storage and arithmetic.
    spf_datapath #(
        .NUM_BINS         (NUM_BINS),
        .MAX_KEPT         (MAX_KEPT),
        .NOISE_WINDOW_MAX (NOISE_WINDOW_MAX),
        .MAG_WIDTH        (MAG_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_magnitude   (i_magnitude),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_peak_freq   (o_peak_freq),
        .o_peak_level  (o_peak_level),
        .o_peak_total  (o_peak_total),
        .o_peak_valid  (o_peak_valid),
        .o_last_peak   (o_last_peak),
        .o_peak_strobe (o_peak_strobe)
    );

`ifndef SYNTHESIS
    // A result beat only comes out of a report in progress.
    a_strobe_in_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_peak_strobe |-> (busy || $past(busy)))
        else $error("result beat outside a report");

    // An empty report is a single closing beat with a zero count.
    a_empty_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_peak_strobe && !o_peak_valid) |-> (o_last_peak && o_peak_total == '0))
        else $error("malformed empty report");

    // A peak beat carries a nonzero count and a level of at most one.
    a_peak_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_peak_strobe && o_peak_valid) |->
        (o_peak_total != '0 && o_peak_level <= LEVEL_W'(65536)))
        else $error("malformed peak beat");
`endif

endmodule

`default_nettype wire

FILE: sim/spectrum_peak_finder_tb.sv
// Self-checking testbench for the spectral peak finder: directed spectra, then random ones.
`default_nettype none

module spectrum_peak_finder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spf_pkg::*;

    localparam int NBINS     = 1024;
    localparam int KEEP_MAX  = 10;
    localparam int WIN_MAX   = 128;
    localparam int STALL_MAX = 150000;
    localparam int ITEMS     = 270;

    typedef struct {
        logic [FREQ_W-1:0]  freq;
        logic [LEVEL_W-1:0] level;
        logic [TOTAL_W-1:0] total;
        logic               valid;
        logic               last;
    } t_peak;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_BIN,
        ROW_BIN_TYPED
    } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [2:0]         idx;
        logic [CFG_W-1:0]   data;
        logic [23:0]        mag;
        logic               last;
        logic [FREQ_W-1:0]  e_freq;
        logic [LEVEL_W-1:0] e_level;
        logic [TOTAL_W-1:0] e_total;
        logic               e_valid;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic [23:0]          i_magnitude = '0;
    logic                 i_last_bin = 1'b0;
    logic [FREQ_W-1:0]    o_peak_freq;
    logic [LEVEL_W-1:0]   o_peak_level;
    logic [TOTAL_W-1:0]   o_peak_total;
    logic                 o_peak_valid;
    logic                 o_last_peak;
    logic                 o_peak_strobe;

    spectrum_peak_finder dut (.*);

    // Shadow of the block: loaded spectrum and register copies.
    logic [23:0]       spec_mem [NBINS];
    int unsigned       bins_loaded = 0;
    logic [NW_W-1:0]   m_window = RST_NOISE_WINDOW;
    logic [GAIN_W-1:0] m_gain   = RST_NOISE_GAIN;
    logic [FIRST_W-1:0] m_first = RST_FIRST_BIN;
    logic [END_W-1:0]  m_end    = RST_END_BIN;
    logic [BW_W-1:0]   m_bw     = RST_BIN_WIDTH;
    logic [WEAK_W-1:0] m_weak   = RST_WEAK_FRACTION;

    t_peak pending_peaks[$];
    int    errors = 0;
    int    idle_cycles = 0;
    int    beats_sent = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned bin_mag(longint unsigned i);
        if (i < bins_loaded && i < NBINS) begin
            return spec_mem[i];
        end
        return 0;
    endfunction

    // Loads one bin; on the last bin works out the whole peak report.
    function automatic void load_bin(input logic [23:0] mag, input logic last,
                                     ref t_peak rpt[$]);
        longint unsigned win[$];
        longint unsigned fq[KEEP_MAX], mg[KEEP_MAX], lv[KEEP_MAX];
        longint unsigned thr, stop, a, b, g, d2, off, pos, f, mx, lvl, tf, tm, tl;
        int n, cnt, kept, mi, j;
        t_peak p;
        rpt.delete();
        if (bins_loaded < NBINS) begin
            spec_mem[bins_loaded] = mag;
            bins_loaded++;
        end
        if (!last) return;

        // Noise floor from the upper median of the window.
        n = (m_window == 0) ? 1 : (m_window > WIN_MAX ? WIN_MAX : int'(m_window));
        for (int i = 0; i < n; i++) win.push_back(bin_mag(longint'(m_first) + i));
        win.sort();
        thr = win[n / 2] * m_gain;

        // Peak search with parabolic refinement.
        stop = (m_end > NBINS) ? NBINS : m_end;
        cnt = 0;
        for (longint unsigned i = longint'(m_first) + 1; i + 1 < stop; i++) begin
            a = bin_mag(i - 1);
            b = bin_mag(i);
            g = bin_mag(i + 1);
            if (b > thr && b > a && b > g) begin
                d2 = 2 * (2 * b - a - g);
                if (g >= a) begin
                    off = (((g - a) << 16) + d2 / 2) / d2;
                    pos = (i << 16) + off;
                end else begin
                    off = (((a - g) << 16) + d2 / 2) / d2;
                    pos = (i << 16) - off;
                end
                f = (pos * m_bw + (64'd1 << 23)) >> 24;
                if (f > 64'hFFFFFF) f = 64'hFFFFFF;
                if (cnt < KEEP_MAX) begin
                    fq[cnt] = f;
                    mg[cnt] = b;
                    cnt++;
                end else begin
                    mi = 0;
                    for (int k = 1; k < KEEP_MAX; k++) if (mg[k] < mg[mi]) mi = k;
                    if (b > mg[mi]) begin
                        fq[mi] = f;
                        mg[mi] = b;
                    end
                end
            end
        end

        // Normalize, drop weak peaks, then a stable sort by frequency.
        mx = 0;
        for (int k = 0; k < cnt; k++) if (mg[k] > mx) mx = mg[k];
        kept = 0;
        for (int k = 0; k < cnt; k++) begin
            lvl = mx ? (mg[k] * 65536 + mx / 2) / mx : 0;
            if (lvl >= m_weak) begin
                fq[kept] = fq[k];
                mg[kept] = mg[k];
                lv[kept] = lvl;
                kept++;
            end
        end
        for (int k = 1; k < kept; k++) begin
            tf = fq[k];
            tm = mg[k];
            tl = lv[k];
            j = k;
            while (j > 0 && fq[j - 1] > tf) begin
                fq[j] = fq[j - 1];
                mg[j] = mg[j - 1];
                lv[j] = lv[j - 1];
                j--;
            end
            fq[j] = tf;
            mg[j] = tm;
            lv[j] = tl;
        end
        bins_loaded = 0;

        if (kept == 0) begin
            p = '{freq: '0, level: '0, total: '0, valid: 1'b0, last: 1'b1};
            rpt.push_back(p);
        end
        for (int k = 0; k < kept; k++) begin
            p.freq  = fq[k][FREQ_W-1:0];
            p.level = lv[k][LEVEL_W-1:0];
            p.total = kept[TOTAL_W-1:0];
            p.valid = 1'b1;
            p.last  = (k + 1 == kept);
            rpt.push_back(p);
        end
    endfunction

    // Waits until the block is idle and every report has come out.
    task automatic wait_quiet();
        while (pending_peaks.size() != 0 || busy) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_NOISE_WINDOW:  m_window = val[NW_W-1:0];
            CFG_NOISE_GAIN:    m_gain   = val[GAIN_W-1:0];
            CFG_FIRST_BIN:     m_first  = val[FIRST_W-1:0];
            CFG_END_BIN:       m_end    = val[END_W-1:0];
            CFG_BIN_WIDTH:     m_bw     = val[BW_W-1:0];
            CFG_WEAK_FRACTION: m_weak   = val[WEAK_W-1:0];
            default: ;
        endcase
    endtask

    // Sends one bin beat after a gap and returns the report it causes.
    task automatic send_bin(input logic [23:0] mag, input logic last, input int gap,
                            ref t_peak rpt[$]);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_magnitude <= mag;
        i_last_bin  <= last;
        do @(posedge i_clk); while (busy);
        beats_sent++;
        load_bin(mag, last, rpt);
    endtask

    // Result checker: each strobe beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_peak e;
        if (i_rst_n && o_peak_strobe) begin
            if (pending_peaks.size() == 0) begin
                $display("%0t: unexpected result freq=%0d level=%0d", $time,
                         o_peak_freq, o_peak_level);
                errors++;
            end else begin
                e = pending_peaks.pop_front();
                if (o_peak_freq !== e.freq || o_peak_level !== e.level ||
                    o_peak_total !== e.total || o_peak_valid !== e.valid ||
                    o_last_peak !== e.last) begin
                    $display("%0t: expected freq=%0d level=%0d total=%0d valid=%0b last=%0b",
                             $time, e.freq, e.level, e.total, e.valid, e.last);
                    $display("%0t: actual   freq=%0d level=%0d total=%0d valid=%0b last=%0b",
                             $time, o_peak_freq, o_peak_level, o_peak_total,
                             o_peak_valid, o_last_peak);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with neither a bin nor a result beat.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_peak_strobe || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_MAX) begin
            $display("spectrum_peak_finder: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    t_row dir_rows[] = '{
        // Reset settings, a lone zero bin: nothing above the floor.
        '{ROW_BIN_TYPED, 0, 0, 24'h0, 1, 0, 0, 0, 0},
        '{ROW_CFG, CFG_NOISE_WINDOW, 1, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_NOISE_GAIN, 1, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_FIRST_BIN, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_END_BIN, 3, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_BIN_WIDTH, 65536, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_WEAK_FRACTION, 65536, 0, 0, 0, 0, 0, 0},
        // Symmetric full-scale peak at bin one: 1.0 Hz at full level.
        '{ROW_BIN, 0, 0, 24'h0, 0, 0, 0, 0, 0},
        '{ROW_BIN, 0, 0, 24'hFFFFFF, 0, 0, 0, 0, 0},
        '{ROW_BIN_TYPED, 0, 0, 24'h0, 1, 256, 65536, 1, 1},
        '{ROW_CFG, CFG_NOISE_WINDOW, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_NOISE_GAIN, 255, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_FIRST_BIN, 1023, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_END_BIN, 2047, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_BIN_WIDTH, 20'hFFFFF, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_WEAK_FRACTION, 0, 0, 0, 0, 0, 0, 0},
        // Window and search past the loaded bins: reads as zero, empty search.
        '{ROW_BIN, 0, 0, 24'hFFFFFF, 0, 0, 0, 0, 0},
        '{ROW_BIN, 0, 0, 24'h0, 0, 0, 0, 0, 0},
        '{ROW_BIN, 0, 0, 24'h1, 0, 0, 0, 0, 0},
        '{ROW_BIN_TYPED, 0, 0, 24'h0, 1, 0, 0, 0, 0},
        // Oversized window, zero gain, equal peaks, end at the store size.
        '{ROW_CFG, CFG_NOISE_WINDOW, 255, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_NOISE_GAIN, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_FIRST_BIN, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_END_BIN, 1024, 0, 0, 0, 0, 0, 0},
        '{ROW_BIN, 0, 0, 24'd3, 0, 0, 0, 0, 0},
        '{ROW_BIN, 0, 0, 24'd9, 0, 0, 0, 0, 0},
        '{ROW_BIN, 0, 0, 24'd2, 0, 0, 0, 0, 0},
        '{ROW_BIN, 0, 0, 24'd9, 0, 0, 0, 0, 0},
        '{ROW_BIN, 0, 0, 24'd1, 0, 0, 0, 0, 0},
        '{ROW_BIN, 0, 0, 24'd0, 1, 0, 0, 0, 0}
    };

    // Draws a fresh register setting, extremes included now and then.
    task automatic random_config();
        write_reg(CFG_NOISE_WINDOW, CFG_W'(($urandom_range(0, 11) == 0) ?
                  $urandom_range(0, 255) : $urandom_range(0, 6)));
        write_reg(CFG_NOISE_GAIN, CFG_W'(($urandom_range(0, 7) == 0) ?
                  $urandom_range(0, 255) : $urandom_range(0, 3)));
        write_reg(CFG_FIRST_BIN, CFG_W'(($urandom_range(0, 9) == 0) ?
                  $urandom_range(0, 1023) : $urandom_range(0, 4)));
        write_reg(CFG_END_BIN, CFG_W'(($urandom_range(0, 9) == 0) ?
                  $urandom_range(0, 2047) : $urandom_range(0, 45)));
        write_reg(CFG_BIN_WIDTH, CFG_W'(($urandom_range(0, 9) == 0) ?
                  0 : $urandom_range(0, 20'hFFFFF)));
        case ($urandom_range(0, 7))
            0, 1:    write_reg(CFG_WEAK_FRACTION, '0);
            2:       write_reg(CFG_WEAK_FRACTION, CFG_W'($urandom_range(65536, 131071)));
            default: write_reg(CFG_WEAK_FRACTION, CFG_W'($urandom_range(0, 40000)));
        endcase
    endtask

    initial begin
        t_peak rpt[$];
        int    len, mode, gap_mode;
        logic [23:0] mag;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows; typed rows replace the predicted report.
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                start <= 1'b0;
                wait_quiet();
                write_reg(dir_rows[r].idx, dir_rows[r].data);
            end else begin
                send_bin(dir_rows[r].mag, dir_rows[r].last, $urandom_range(0, 3), rpt);
                if (dir_rows[r].kind == ROW_BIN_TYPED) begin
                    pending_peaks.push_back('{freq: dir_rows[r].e_freq,
                                              level: dir_rows[r].e_level,
                                              total: dir_rows[r].e_total,
                                              valid: dir_rows[r].e_valid, last: 1'b1});
                end else begin
                    foreach (rpt[k]) pending_peaks.push_back(rpt[k]);
                end
            end
        end

        // Random spectra under fresh settings.
        while (beats_sent < ITEMS) begin
            start <= 1'b0;
            wait_quiet();
            random_config();
            len = $urandom_range(1, 40);
            mode = $urandom_range(0, 3);
            gap_mode = $urandom_range(0, 2);
            for (int b = 0; b < len; b++) begin
                case (mode)
                    0:       mag = 24'($urandom_range(0, 24'hFFFFFF));
                    1:       mag = 24'($urandom_range(0, 7));
                    2:       mag = b[0] ? 24'($urandom_range(0, 24'hFFFFFF))
                                        : 24'($urandom_range(0, 255));
                    default: mag = b[0] ? 24'($urandom_range(5, 8)) : 24'($urandom_range(0, 4));
                endcase
                send_bin(mag, b == len - 1, (gap_mode == 0) ? 0 : $urandom_range(0, 18), rpt);
                foreach (rpt[k]) pending_peaks.push_back(rpt[k]);
            end
        end

        start <= 1'b0;
        wait_quiet();
        if (errors == 0) begin
            $display("spectrum_peak_finder: match");
        end else begin
            $display("spectrum_peak_finder: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
